// ===== sv/dtq_pkg.sv =====
// Shared types and constants for the deadline timer queue.
// No dependencies; imported by dtq_cell, dtq_row and deadline_timer_queue_top.
package dtq_pkg;

   localparam int DEPTH     = 16;               // queue slots, 2..64
   localparam int MAX_POPS  = 16;               // expiries per tick, at most
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int POP_W     = $clog2(MAX_POPS);
   localparam int ID_W      = 4;
   localparam int DL_W      = 64;
   localparam int PERIOD_W  = 48;
   localparam int WINDOW_W  = 30;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(500000);

   // input actions
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_CANCEL = 2'd2;

   // result kinds
   localparam logic [1:0] EV_EXPIRED = 2'd0;
   localparam logic [1:0] EV_START   = 2'd1;
   localparam logic [1:0] EV_CANCEL  = 2'd2;

   // cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_REMOVE = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;
   localparam logic [1:0] CELL_POP    = 2'd3;

   typedef struct packed {
      logic            valid;
      logic [DL_W-1:0] dl;
      logic [ID_W-1:0] id;
   } entry_type;

   localparam entry_type ENTRY_EMPTY = '{valid: 1'b0, dl: '0, id: '0};

   // broadcast to every cell
   typedef struct packed {
      logic [1:0]      op;
      logic [DL_W-1:0] key;      // new deadline (start) or due threshold (tick)
      logic [ID_W-1:0] tgt_id;   // timer to drop / insert
   } cell_ctrl_type;

   // row status back to the sequencer
   typedef struct packed {
      entry_type       head;
      logic            head_due;
      logic            next_due;
      logic            found;
      logic [DL_W-1:0] found_dl;
   } row_stat_type;

endpackage

// ===== sv/dtq_cell.sv =====
// One queue slot: holds an entry and trades it with its neighbors.
// Depends on dtq_pkg.
module dtq_cell
   import dtq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_ent,
   input  logic          left_gt,
   input  logic          after_in,
   input  entry_type     right_ent,
   output entry_type     ent,
   output logic          gt,
   output logic          hit,
   output logic          after_out,
   output logic          due
);

   entry_type       ent_ff, ent_in;
   logic [DL_W-1:0] diff;

   assign ent       = ent_ff;
   assign hit       = ent_ff.valid && (ent_ff.id == ctrl.tgt_id);
   assign after_out = after_in || hit;
   // empty slots sort after everything
   assign gt        = !ent_ff.valid || (ent_ff.dl > ctrl.key);
   assign diff      = ctrl.key - ent_ff.dl;
   assign due       = ent_ff.valid && !diff[DL_W-1];

   always_comb begin
      ent_in = ent_ff;
      case (ctrl.op)
         CELL_REMOVE: begin
            if (after_out) ent_in = right_ent;
         end
         CELL_POP: begin
            ent_in = right_ent;
         end
         CELL_INSERT: begin
            if (gt) begin
               if (left_gt) ent_in = left_ent;
               else ent_in = '{valid: 1'b1, dl: ctrl.key, id: ctrl.tgt_id};
            end
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff.dl <= ent_in.dl;
      ent_ff.id <= ent_in.id;
      if (reset) ent_ff.valid <= 1'b0;
      else ent_ff.valid <= ent_in.valid;
   end

endmodule

// ===== sv/dtq_row.sv =====
// Row of DEPTH cells, slot 0 is the head; wires neighbors and gathers status.
// Depends on dtq_pkg and dtq_cell.
module dtq_row
   import dtq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   output row_stat_type  stat
);

   entry_type ent       [DEPTH];
   entry_type left_ent  [DEPTH];
   entry_type right_ent [DEPTH];
   logic [DEPTH-1:0] gt, hit, after_o, due, left_gt, after_i;
   logic [DL_W-1:0]  found_dl;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_ent[i] = ENTRY_EMPTY;
         assign left_gt[i]  = 1'b0;
         assign after_i[i]  = 1'b0;
      end else begin : g_mid
         assign left_ent[i] = ent[i-1];
         assign left_gt[i]  = gt[i-1];
         assign after_i[i]  = after_o[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_ent[i] = ENTRY_EMPTY;
      end else begin : g_inner
         assign right_ent[i] = ent[i+1];
      end

      dtq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .left_ent  (left_ent[i]),
         .left_gt   (left_gt[i]),
         .after_in  (after_i[i]),
         .right_ent (right_ent[i]),
         .ent       (ent[i]),
         .gt        (gt[i]),
         .hit       (hit[i]),
         .after_out (after_o[i]),
         .due       (due[i])
      );
   end

   // ids are unique in the queue, so at most one hit
   always_comb begin
      found_dl = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit[i]) found_dl = found_dl | ent[i].dl;
      end
   end

   assign stat.head     = ent[0];
   assign stat.head_due = due[0];
   assign stat.next_due = due[1];
   assign stat.found    = |hit;
   assign stat.found_dl = found_dl;

endmodule

// ===== sv/deadline_timer_queue_top.sv =====
// Deadline timer queue, top level: sequencer, output register, window register.
// Depends on dtq_pkg and dtq_row.
//
// Usage:
//   req_*  : one item per action. Tick (action 0) pops every queued timer whose
//            deadline <= req_timestamp + window, one rsp item each, ascending,
//            at most 16 per tick, rsp_last on the final one (none if nothing due).
//            Start (1) sets deadline = timestamp + period, drops any queued entry
//            of that timer and inserts after equal deadlines; one rsp item.
//            Cancel (2) drops the timer; one rsp item, deadline 0 if not queued.
//            Action 3 is taken and ignored.
//   csr_*  : write of the 30-bit early window in ns; always ready. Write only
//            while the block is idle.
//   rsp_*  : results through a single output register.
// Timing: req_ready is high only in the idle state. A start runs a drop pass,
//   an insert pass and a result load; a cancel a drop pass and a result load;
//   a tick one pop step per popped timer (one step if none is due). Each pass is
//   one shift step of the cell row, so the cost is independent of queue depth.
// Reset: synchronous; empties the queue, window back to 500000 ns.
// Stall: while rsp_ready is low the held result stays put and the sequencer
//   waits for the output register before loading the next one; a new item may
//   be accepted while a result is still waiting.
module deadline_timer_queue_top
   import dtq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic [PERIOD_W-1:0] req_period,
   input  logic [DL_W-1:0]     req_timestamp,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_event_kind,
   output logic [ID_W-1:0]     rsp_timer_id_res,
   output logic [DL_W-1:0]     rsp_deadline,
   output logic                rsp_last,
   // window register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WINDOW_W-1:0] csr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REMOVE = 3'd1;
   localparam logic [2:0] ST_INSERT = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_POP    = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [DL_W-1:0]     key_ff, key_in;       // new deadline, tick threshold or result
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [POP_W-1:0]    pops_ff, pops_in;
   logic [WINDOW_W-1:0] window_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [DL_W-1:0]     rsp_dl_ff, rsp_dl_in;
   logic                rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   row_stat_type  stat;
   logic          out_free, load, pop_last;

   dtq_row u_row (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // last expiry when the next slot is not due or the per-tick cap is reached
   assign pop_last  = !stat.next_due || (pops_ff == POP_W'(MAX_POPS - 1));

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      id_in       = id_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      pops_in     = pops_ff;
      load        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_dl_in   = rsp_dl_ff;
      rsp_last_in = rsp_last_ff;
      ctrl.op     = CELL_HOLD;
      ctrl.key    = key_ff;
      ctrl.tgt_id = id_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in = req_timer_id;
               case (req_action)
                  ACT_TICK: begin
                     key_in   = req_timestamp + {{(DL_W-WINDOW_W){1'b0}}, window_ff};
                     pops_in  = '0;
                     state_in = ST_POP;
                  end
                  ACT_START: begin
                     key_in   = req_timestamp + {{(DL_W-PERIOD_W){1'b0}}, req_period};
                     kind_in  = EV_START;
                     state_in = ST_REMOVE;
                  end
                  ACT_CANCEL: begin
                     kind_in  = EV_CANCEL;
                     state_in = ST_REMOVE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REMOVE: begin
            ctrl.op = CELL_REMOVE;
            if (stat.found) count_in = count_ff - CNT_W'(1);
            if (kind_ff == EV_CANCEL) begin
               key_in   = stat.found ? stat.found_dl : '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            // full queue: timer dropped, result still reported
            if (count_ff < CNT_W'(DEPTH)) begin
               ctrl.op  = CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_kind_in = kind_ff;
               rsp_id_in   = id_ff;
               rsp_dl_in   = key_ff;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_POP: begin
            if (!stat.head_due) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ctrl.op     = CELL_POP;
               load        = 1'b1;
               rsp_kind_in = EV_EXPIRED;
               rsp_id_in   = stat.head.id;
               rsp_dl_in   = stat.head.dl;
               rsp_last_in = pop_last;
               count_in    = count_ff - CNT_W'(1);
               pops_in     = pops_ff + POP_W'(1);
               if (pop_last) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) window_ff <= csr_data;
      end
      kind_ff <= kind_in;
      id_ff   <= id_in;
      key_ff  <= key_in;
      pops_ff <= pops_in;
      if (load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_dl_ff   <= rsp_dl_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_timer_id_res = rsp_id_ff;
   assign rsp_deadline     = rsp_dl_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== verif/dtq_board_pkg.sv =====
// Scoreboard for the deadline timer queue: a sorted-queue predictor plus the
// list of results still owed by the block. Depends on dtq_pkg.
package dtq_board_pkg;
   import dtq_pkg::*;

   typedef struct packed {
      logic [1:0]      kind;
      logic [ID_W-1:0] id;
      logic [DL_W-1:0] dl;
      logic            last;
   } timer_event_type;

   class timer_queue_board;
      logic [DL_W-1:0]     slot_dl[DEPTH];
      logic [ID_W-1:0]     slot_id[DEPTH];
      int unsigned         queued;
      logic [WINDOW_W-1:0] window;
      timer_event_type     awaited[$];
      int unsigned         mismatches;

      function new();
         queued     = 0;
         window     = WINDOW_RESET;
         mismatches = 0;
      endfunction

      function void set_window(logic [WINDOW_W-1:0] value);
         window = value;
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function void add_event(logic [1:0] kind, logic [ID_W-1:0] id,
                              logic [DL_W-1:0] dl, logic last);
         timer_event_type ev;
         ev.kind = kind;
         ev.id   = id;
         ev.dl   = dl;
         ev.last = last;
         awaited.push_back(ev);
      endfunction

      // close the gap left at pos
      function void drop_slot(int unsigned pos);
         for (int unsigned i = pos; i + 1 < queued; i++) begin
            slot_dl[i] = slot_dl[i+1];
            slot_id[i] = slot_id[i+1];
         end
         queued--;
      endfunction

      function bit take_timer(logic [ID_W-1:0] id, output logic [DL_W-1:0] dl);
         for (int unsigned i = 0; i < queued; i++) begin
            if (slot_id[i] == id) begin
               dl = slot_dl[i];
               drop_slot(i);
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // accepted request item: update the queue and queue up the owed results
      function void note_request(logic [1:0] action, logic [ID_W-1:0] id,
                                 logic [PERIOD_W-1:0] period, logic [DL_W-1:0] stamp);
         logic [DL_W-1:0] dl;
         logic [DL_W-1:0] gap;
         int unsigned     pops;
         int unsigned     pos;
         pops = 0;
         case (action)
            ACT_TICK: begin
               while (queued > 0 && pops < MAX_POPS) begin
                  gap = stamp + {{(DL_W-WINDOW_W){1'b0}}, window} - slot_dl[0];
                  if (gap[DL_W-1])
                     break;
                  add_event(EV_EXPIRED, slot_id[0], slot_dl[0], 1'b0);
                  drop_slot(0);
                  pops++;
               end
               if (pops > 0)
                  awaited[awaited.size()-1].last = 1'b1;
            end
            ACT_START: begin
               dl = stamp + {{(DL_W-PERIOD_W){1'b0}}, period};
               void'(take_timer(id, gap));
               if (queued < DEPTH) begin
                  pos = queued;
                  for (int unsigned i = 0; i < queued; i++) begin
                     if (slot_dl[i] > dl) begin
                        pos = i;
                        break;
                     end
                  end
                  for (int unsigned i = queued; i > pos; i--) begin
                     slot_dl[i] = slot_dl[i-1];
                     slot_id[i] = slot_id[i-1];
                  end
                  slot_dl[pos] = dl;
                  slot_id[pos] = id;
                  queued++;
               end
               add_event(EV_START, id, dl, 1'b1);
            end
            ACT_CANCEL: begin
               if (!take_timer(id, dl))
                  dl = '0;
               add_event(EV_CANCEL, id, dl, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void check_result(timer_event_type got);
         timer_event_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result: event_kind %0d timer_id_res %0d deadline %h",
                   got.kind, got.id, got.dl);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatches++;
         end
         if (got.id !== want.id) begin
            $error("timer_id_res: expected %0d, actual %0d", want.id, got.id);
            mismatches++;
         end
         if (got.dl !== want.dl) begin
            $error("deadline: expected %h, actual %h", want.dl, got.dl);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== verif/deadline_timer_queue_top_test.sv =====
// Self-checking bench for deadline_timer_queue_top: directed and random timer
// traffic with random idling and a long output stall. Depends on dtq_pkg,
// dtq_board_pkg and the block's RTL.
module deadline_timer_queue_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dtq_pkg::*;
   import dtq_board_pkg::*;

   localparam logic [1:0]          ACT_IGNORED   = 2'd3;       // accepted, no effect
   localparam logic [WINDOW_W-1:0] WINDOW_TOP    = WINDOW_W'(1_000_000_000);
   localparam int                  SETTLE_CYCLES = 24;         // 16 pops + margin
   localparam int                  HOLD_CYCLES   = 400;        // long output stall

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [1:0]          req_action     = '0;
   logic [ID_W-1:0]     req_timer_id   = '0;
   logic [PERIOD_W-1:0] req_period     = '0;
   logic [DL_W-1:0]     req_timestamp  = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [1:0]          rsp_event_kind;
   logic [ID_W-1:0]     rsp_timer_id_res;
   logic [DL_W-1:0]     rsp_deadline;
   logic                rsp_last;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic [WINDOW_W-1:0] csr_data       = '0;

   // idle rates in percent, set per phase by the main sequence
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   // main bumps hold_requests; the receiver notices and stalls on its own count
   int unsigned hold_requests  = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;

   timer_queue_board board;

   deadline_timer_queue_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_timer_id     (req_timer_id),
      .req_period       (req_period),
      .req_timestamp    (req_timestamp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_timer_id_res (rsp_timer_id_res),
      .rsp_deadline     (rsp_deadline),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop, with FAIL, if the run never finishes.
   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // Result side: random back-pressure, or a long solid stall when requested.
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: values seen here are the ones present just before the edge.
   always @(posedge clock) begin
      timer_event_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.kind = rsp_event_kind;
            got.id   = rsp_timer_id_res;
            got.dl   = rsp_deadline;
            got.last = rsp_last;
            board.check_result(got);
         end
         if (req_valid && req_ready)
            board.note_request(req_action, req_timer_id, req_period, req_timestamp);
      end
   end

   // Offer one request item, with optional idle cycles first; returns at the
   // edge where it is taken, so a following call can keep valid high.
   task automatic send_request(input logic [1:0] action, input logic [ID_W-1:0] id,
                               input logic [PERIOD_W-1:0] period,
                               input logic [DL_W-1:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= action;
      req_timer_id  <= id;
      req_period    <= period;
      req_timestamp <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, drain every owed result, then give a silent tick (no results)
   // time to finish inside the block.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_window(value);
   endtask

   // Random traffic around a moving clock value. Starts and cancels use the
   // current time, ticks move it forward; the spread scales with the window
   // so some timers are due and some are not. Ignored actions are not counted.
   task automatic run_random_phase(input int unsigned count, input logic [DL_W-1:0] start_time);
      logic [DL_W-1:0]     now;
      logic [DL_W-1:0]     stamp;
      logic [PERIOD_W-1:0] period;
      logic [1:0]          action;
      int unsigned         span;
      int unsigned         sent;
      int unsigned         pick;
      now  = start_time;
      span = 2 * board.window + 2_000_000;
      sent = 0;
      while (sent < count) begin
         pick   = $urandom_range(99);
         period = PERIOD_W'({$urandom, $urandom});
         stamp  = now;
         if (pick < 5) begin
            action = ACT_IGNORED;
            stamp  = {$urandom, $urandom};
         end else if (pick < 50) begin
            action = ACT_START;
            // mostly near-term deadlines, now and then a far one
            if ($urandom_range(9) != 0)
               period = PERIOD_W'($urandom_range(0, span));
         end else if (pick < 65) begin
            action = ACT_CANCEL;
         end else begin
            action = ACT_TICK;
            now    = now + DL_W'($urandom_range(0, span / 2));
            // an occasional stray timestamp, far ahead or behind
            stamp  = ($urandom_range(19) == 0) ? {$urandom, $urandom} : now;
         end
         send_request(action, ID_W'($urandom_range(15)), period, stamp);
         if (action != ACT_IGNORED)
            sent++;
      end
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset window (500 us), light sender idling, heavy stall.
      send_idle_pct  = 17;
      recv_stall_pct = 82;
      send_request(ACT_IGNORED, '1, '1, '1);                 // all ones, no effect
      send_request(ACT_CANCEL, 4'd5, '0, '0);                // cancel, not queued
      send_request(ACT_TICK, '0, '0, '0);                    // tick on empty queue
      send_request(ACT_START, 4'd0, '0, '0);                 // zero period at time zero
      send_request(ACT_START, 4'd15, '1, '1);                // deadline wraps past 2^64
      send_request(ACT_START, 4'd3, 48'd1_000_000, 64'd1000);
      send_request(ACT_START, 4'd4, 48'd1_000_000, 64'd1000); // equal deadline, after 3
      send_request(ACT_START, 4'd3, 48'd1_000_000, 64'd1000); // restart: moves behind 4
      send_request(ACT_CANCEL, 4'd4, '0, 64'd1000);          // cancel, queued
      // fill every slot, timer 4 comes back
      for (int i = 1; i < 15; i++) begin
         if (i != 3)
            send_request(ACT_START, ID_W'(i), PERIOD_W'($urandom_range(0, 3_000_000)),
                         64'd2000);
      end
      send_request(ACT_TICK, '0, '0, 64'h0001_0000_0000_0000); // all 16 due at once
      send_request(ACT_TICK, '1, '1, '1);                     // empty again, nothing due
      settle();

      // Zero window: a timer fires exactly at its deadline.
      write_window('0);
      run_random_phase(25, DL_W'($urandom_range(0, 1000)));
      settle();

      // Large window (WINDOW_TOP), roles of sender and receiver swapped.
      write_window(WINDOW_TOP);
      send_idle_pct  = 82;
      recv_stall_pct = 17;
      run_random_phase(24, {$urandom, $urandom});
      settle();

      // Random window, no idling, clock just below the wrap point. A long
      // output stall at the start backs the block up until req_ready drops.
      write_window(WINDOW_W'($urandom_range(1, 4_000_000)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      run_random_phase(24, 64'hFFFF_FFFF_FFFF_FFFF - DL_W'($urandom_range(0, 20_000_000)));
      settle();

      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
